/* src/frs_pkg.sv */
// ----------------------------------------------------------------------------
// frs_pkg
// Types and constants shared by the fitness rank sorter modules.
// ----------------------------------------------------------------------------
package frs_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int KEY_W       = 32;

    typedef struct packed {
        logic signed [KEY_W-1:0] fitness_value;
        logic                    last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] ranked_fitness;
        logic [ADDR_W-1:0]       original_index;
        logic                    run_end;
        logic                    overflow;
    } t_out_item;

    // One stored entry: fitness and arrival index.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [ADDR_W-1:0]       idx;
    } t_entry;

    // Control from the sequencer to the selector.
    typedef struct packed {
        logic new_run;
        logic cand_valid;
        logic finish;
    } t_sel_ctl;

    // True when entry a ranks ahead of entry b: higher fitness, then lower index.
    function automatic logic ranks_before(input t_entry a, input t_entry b);
        logic result;
        if (a.key != b.key) begin
            result = (a.key > b.key);
        end else begin
            result = (a.idx < b.idx);
        end
        return result;
    endfunction

endpackage

/* src/frs_store.sv */
// ----------------------------------------------------------------------------
// frs_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module frs_store (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [frs_pkg::ADDR_W-1:0] i_wr_addr,
    input  frs_pkg::t_entry           i_wr_data,
    input  logic                      i_rd_en,
    input  logic [frs_pkg::ADDR_W-1:0] i_rd_addr,
    output frs_pkg::t_entry           o_rd_data
);

    frs_pkg::t_entry r_mem [frs_pkg::STORE_DEPTH];
    frs_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/frs_select.sv */
// ----------------------------------------------------------------------------
// frs_select
// Scan selector: over one pass through the store, keeps the best entry that
// ranks strictly after the previously emitted one.
// ----------------------------------------------------------------------------
module frs_select (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  frs_pkg::t_sel_ctl i_ctl,
    input  frs_pkg::t_entry   i_cand,
    output frs_pkg::t_entry   o_pick
);

    frs_pkg::t_entry r_best, n_best;
    frs_pkg::t_entry r_prev;
    logic            r_have_best, n_have_best;
    logic            r_have_prev;
    logic            eligible;
    logic            better;

    always_comb begin
        eligible = !r_have_prev || frs_pkg::ranks_before(r_prev, i_cand);
        better   = !r_have_best || frs_pkg::ranks_before(i_cand, r_best);
        n_best   = (i_ctl.cand_valid && eligible && better) ? i_cand : r_best;
        n_have_best = r_have_best || (i_ctl.cand_valid && eligible);
    end

    assign o_pick = n_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
            r_have_prev <= 1'b0;
        end else if (i_ctl.new_run) begin
            r_have_best <= 1'b0;
            r_have_prev <= 1'b0;
        end else if (i_ctl.finish) begin
            // the pick becomes the threshold for the next pass
            r_have_best <= 1'b0;
            r_have_prev <= 1'b1;
        end else begin
            r_have_best <= n_have_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        if (i_ctl.finish) begin
            r_prev <= n_best;
        end
    end

endmodule

/* src/fitness_rank_sorter.sv */
// ----------------------------------------------------------------------------
// fitness_rank_sorter
// Collects signed Q16.16 fitness values and emits them ranked, highest first.
// ----------------------------------------------------------------------------
// An item is taken whenever busy is low; items that are not last leave busy
// low, so they may arrive every cycle. The item marked last starts ranking:
// busy rises and, for n stored entries, n passes run over the single read
// port of the entry memory, one result per pass; each pass reads every stored
// entry in turn (S_SCAN) and then emits its pick (S_DRAIN). Each result is
// shown for one cycle with o_strobe high and cannot be held off; ties leave
// with the lower arrival index first. Busy falls in the cycle of the final
// result, and a new run may start then. Items past POP_CAPACITY are dropped
// and flag overflow on every result of that run.
// ----------------------------------------------------------------------------
module fitness_rank_sorter #(
    parameter int POP_CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  frs_pkg::t_in_item   i_item,
    output logic                busy,
    output logic                o_strobe,
    output frs_pkg::t_out_item  o_result
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    localparam logic [frs_pkg::COUNT_W-1:0] CAP = frs_pkg::COUNT_W'(POP_CAPACITY);

    t_state                        r_state, n_state;
    logic [frs_pkg::COUNT_W-1:0]   r_count, n_count;
    logic                          r_ovf, n_ovf;
    logic [frs_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [frs_pkg::ADDR_W-1:0]    r_rank, n_rank;
    logic [frs_pkg::ADDR_W-1:0]    last_pos;
    logic                          r_pv;
    logic                          r_strobe;
    frs_pkg::t_out_item            r_result;

    logic                          accept;
    logic                          wr_en;
    frs_pkg::t_entry               wr_data;
    logic                          rd_en;
    frs_pkg::t_entry               rd_data;
    frs_pkg::t_sel_ctl             sel_ctl;
    frs_pkg::t_entry               pick;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign wr_en    = accept && (r_count < CAP);
    assign wr_data  = '{key: i_item.fitness_value, idx: r_count[frs_pkg::ADDR_W-1:0]};
    assign last_pos = frs_pkg::ADDR_W'(r_count - frs_pkg::COUNT_W'(1));
    assign rd_en    = (r_state == S_SCAN);

    always_comb begin
        sel_ctl.new_run    = accept && i_item.last_item;
        sel_ctl.cand_valid = r_pv;
        sel_ctl.finish     = r_pv && (r_state == S_DRAIN);
    end

    frs_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[frs_pkg::ADDR_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    frs_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sel_ctl),
        .i_cand  (rd_data),
        .o_pick  (pick)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_addr  = r_addr;
        n_rank  = r_rank;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_count < CAP) begin
                        n_count = r_count + frs_pkg::COUNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.last_item) begin
                        n_state = S_SCAN;
                        n_addr  = '0;
                        n_rank  = '0;
                    end
                end
            end
            S_SCAN: begin
                if (r_addr == last_pos) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + frs_pkg::ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                // last read of the pass lands here; emit, then start the next pass or go idle after the final rank
                if (r_rank == last_pos) begin
                    n_state = S_IDLE;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end else begin
                    n_state = S_SCAN;
                    n_addr  = '0;
                    n_rank  = r_rank + frs_pkg::ADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_addr   <= '0;
            r_rank   <= '0;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_addr   <= n_addr;
            r_rank   <= n_rank;
            r_pv     <= rd_en;
            r_strobe <= sel_ctl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel_ctl.finish) begin
            r_result.ranked_fitness <= pick.key;
            r_result.original_index <= pick.idx;
            r_result.run_end        <= (r_rank == last_pos);
            r_result.overflow       <= r_ovf;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
